[rtl/core/mspi_pkg.sv]
// ----------------------------------------------------------------------------
// mspi_pkg
// Shared types and constants for the motor speed PI controller: event codes,
// configuration register indexes, field widths and reset values.
// ----------------------------------------------------------------------------
package mspi_pkg;

  // Field widths.
  localparam int unsigned OpW     = 2;
  localparam int unsigned SpeedW  = 8;
  localparam int unsigned DreqW   = 8;
  localparam int unsigned DeltaW  = 16;
  localparam int unsigned DriveW  = 16;
  localparam int unsigned PosW    = 32;
  localparam int unsigned GainW   = 16;
  localparam int unsigned LimitW  = 15;
  localparam int unsigned DivW    = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 16;

  // Fixed point: gains carry twelve fraction bits.
  localparam int unsigned FracBits = 12;

  // Event codes.
  typedef enum logic [OpW-1:0] {
    OpCommand  = 2'd0,
    OpTick     = 2'd1,
    OpDirEdge  = 2'd2,
    OpOverflow = 2'd3
  } opcode_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgPropGain  = 2'd0,
    CfgIntegGain = 2'd1,
    CfgIntegLim  = 2'd2,
    CfgTickDiv   = 2'd3
  } cfg_idx_e;

  // Reset values.
  localparam logic [GainW-1:0]  PropGainRst  = 16'd12288;
  localparam logic [GainW-1:0]  IntegGainRst = 16'd1638;
  localparam logic [LimitW-1:0] IntegLimRst  = 15'd200;
  localparam logic [DivW-1:0]   TickDivRst   = 8'd8;

  // Direction request value that selects reverse, and the forward level.
  localparam logic [DreqW-1:0] DreqReverse = 8'd1;
  localparam logic             DirForward  = 1'b1;

  // Amount added to the position total on a counter overflow.
  localparam logic [PosW-1:0] OvfStep = 32'h0001_0000;

endpackage

[rtl/core/motor_speed_pi_controller.sv]
// ----------------------------------------------------------------------------
// motor_speed_pi_controller
// Event driven PI speed regulator with integral clamp, position total and
// direction edge checking.
// ----------------------------------------------------------------------------
// The block takes one event word per clock cycle while out_ready_i is high,
// and returns exactly one result word for each. Events land in an input
// register; out_valid_o rises when an event moves on from that register
// into the result register, which it does once that one is free. The regulation
// step (one 17x17 and one 16x17 multiply, the sum, rounding toward zero and
// saturation) runs in a single pass from that register into the result
// register, and the controller state updates on the same edge. A result that
// waits on out_ready_i does not stop the input register from filling, so a
// stall costs at most one extra word of buffering before in_ready_o drops.
// Configuration writes are taken in every cycle and must only be issued while
// no event is in flight.
module motor_speed_pi_controller (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mspi_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [mspi_pkg::CfgDatW-1:0]        cfg_data_i,
  // Event channel.
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [mspi_pkg::OpW-1:0]            opcode_i,
  input  logic [mspi_pkg::SpeedW-1:0]         target_speed_i,
  input  logic [mspi_pkg::DreqW-1:0]          direction_request_i,
  input  logic [mspi_pkg::DeltaW-1:0]         encoder_delta_i,
  input  logic                                direction_level_i,
  // Result channel.
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [mspi_pkg::DriveW-1:0]  drive_value_o,
  output logic                                drive_updated_o,
  output logic                                direction_pin_o,
  output logic signed [mspi_pkg::PosW-1:0]    position_total_o,
  output logic                                edge_error_o
);
  import mspi_pkg::*;

  localparam int unsigned ErrW  = DeltaW + 1;
  localparam int unsigned AccW  = ErrW + 1;
  localparam int unsigned SumW  = ErrW + GainW + 1;
  localparam int unsigned QuotW = SumW - FracBits;

  // Configuration registers.
  logic [GainW-1:0]  prop_gain_q;
  logic [GainW-1:0]  integ_gain_q;
  logic [LimitW-1:0] integ_limit_q;
  logic [DivW-1:0]   tick_div_q;

  // Controller state.
  logic [SpeedW-1:0]        target_q,   target_d;
  logic signed [DriveW-1:0] integ_q,    integ_d;
  logic [DivW-1:0]          tick_cnt_q, tick_cnt_d;
  logic [PosW-1:0]          total_q,    total_d;
  logic                     sensed_q,   sensed_d;
  logic signed [DriveW-1:0] drive_q,    drive_d;
  logic                     dir_pin_q,  dir_pin_d;
  logic                     updated_d,  edge_err_d;

  // Input register.
  logic              s1_valid_q;
  opcode_e           s1_op_q;
  logic [SpeedW-1:0] s1_speed_q;
  logic [DreqW-1:0]  s1_dreq_q;
  logic [DeltaW-1:0] s1_delta_q;
  logic              s1_level_q;

  // Result register.
  logic out_valid_q;

  logic s1_adv;
  logic s1_fire;

  // Handshake: the input register moves on whenever the result register is
  // free or being emptied this cycle.
  assign s1_adv      = !out_valid_q || out_ready_i;
  assign s1_fire     = s1_valid_q && s1_adv;
  assign in_ready_o  = !s1_valid_q || s1_adv;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_gain_q   <= PropGainRst;
      integ_gain_q  <= IntegGainRst;
      integ_limit_q <= IntegLimRst;
      tick_div_q    <= TickDivRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgPropGain:  prop_gain_q   <= cfg_data_i;
        CfgIntegGain: integ_gain_q  <= cfg_data_i;
        CfgIntegLim:  integ_limit_q <= cfg_data_i[LimitW-1:0];
        CfgTickDiv:   tick_div_q    <= cfg_data_i[DivW-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_op_q    <= opcode_e'(opcode_i);
      s1_speed_q <= target_speed_i;
      s1_dreq_q  <= direction_request_i;
      s1_delta_q <= encoder_delta_i;
      s1_level_q <= direction_level_i;
    end
  end

  // Regulation datapath: error, clamped integral, gain products, rounding
  // toward zero and saturation to the drive width.
  logic signed [ErrW-1:0]   err;
  logic signed [AccW-1:0]   acc_raw;
  logic signed [AccW-1:0]   lim_s;
  logic signed [DriveW-1:0] acc_clamp;
  logic signed [SumW-1:0]   prop_prod;
  logic signed [SumW-1:0]   integ_prod;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   sum_biased;
  logic signed [QuotW-1:0]  quot;
  logic signed [DriveW-1:0] drive_sat;
  logic [PosW-1:0]          delta_ext;
  logic [PosW-1:0]          total_delta;

  // The target used by a regulation step is the stored one.
  assign err     = $signed({{(ErrW-SpeedW){1'b0}}, target_q}) -
                   $signed({1'b0, s1_delta_q});
  assign acc_raw = AccW'(integ_q) + AccW'(err);
  assign lim_s   = $signed({{(AccW-LimitW){1'b0}}, integ_limit_q});

  always_comb begin
    if (acc_raw > lim_s) begin
      acc_clamp = DriveW'(lim_s);
    end else if (acc_raw < -lim_s) begin
      acc_clamp = DriveW'(-lim_s);
    end else begin
      acc_clamp = acc_raw[DriveW-1:0];
    end
  end

  assign prop_prod  = SumW'(err) * SumW'($signed({1'b0, prop_gain_q}));
  assign integ_prod = SumW'(acc_clamp) * SumW'($signed({1'b0, integ_gain_q}));
  assign sum        = prop_prod + integ_prod;
  // A negative sum gets a bias so that the arithmetic shift truncates
  // toward zero.
  assign sum_biased = sum[SumW-1] ? (sum + SumW'((1 << FracBits) - 1)) : sum;
  assign quot       = QuotW'(sum_biased >>> FracBits);

  always_comb begin
    if (quot > QuotW'(32767)) begin
      drive_sat = 16'sh7FFF;
    end else if (quot < -QuotW'(32768)) begin
      drive_sat = 16'sh8000;
    end else begin
      drive_sat = quot[DriveW-1:0];
    end
  end

  // Encoder delta applied under the current sensed direction.
  assign delta_ext   = PosW'(s1_delta_q);
  assign total_delta = (sensed_q == DirForward) ? (total_q + delta_ext)
                                                : (total_q - delta_ext);

  // Next controller state for the event in the input register.
  always_comb begin
    target_d   = target_q;
    integ_d    = integ_q;
    tick_cnt_d = tick_cnt_q;
    total_d    = total_q;
    sensed_d   = sensed_q;
    drive_d    = drive_q;
    dir_pin_d  = dir_pin_q;
    updated_d  = 1'b0;
    edge_err_d = 1'b0;
    unique case (s1_op_q)
      OpCommand: begin
        target_d  = s1_speed_q;
        dir_pin_d = (s1_dreq_q == DreqReverse) ? ~DirForward : DirForward;
        drive_d   = DriveW'(s1_speed_q);
        updated_d = 1'b1;
        total_d   = '0;
        integ_d   = '0;
      end
      OpTick: begin
        if (tick_cnt_q == tick_div_q) begin
          tick_cnt_d = '0;
          total_d    = total_delta;
          integ_d    = acc_clamp;
          if (err != '0) begin
            drive_d   = drive_sat;
            updated_d = 1'b1;
          end
        end else begin
          tick_cnt_d = tick_cnt_q + 1'b1;
        end
      end
      OpDirEdge: begin
        if (s1_level_q != sensed_q) begin
          total_d  = total_delta;
          sensed_d = s1_level_q;
        end else begin
          edge_err_d = 1'b1;
        end
      end
      OpOverflow: begin
        total_d = total_q + OvfStep;
      end
      default: ;
    endcase
  end

  // State and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      integ_q     <= '0;
      tick_cnt_q  <= '0;
      total_q     <= '0;
      sensed_q    <= DirForward;
      drive_q     <= '0;
      dir_pin_q   <= DirForward;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_fire) begin
        target_q   <= target_d;
        integ_q    <= integ_d;
        tick_cnt_q <= tick_cnt_d;
        total_q    <= total_d;
        sensed_q   <= sensed_d;
        drive_q    <= drive_d;
        dir_pin_q  <= dir_pin_d;
      end
      if (s1_adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      drive_value_o    <= drive_d;
      drive_updated_o  <= updated_d;
      direction_pin_o  <= dir_pin_d;
      position_total_o <= total_d;
      edge_error_o     <= edge_err_d;
    end
  end

endmodule

[verif/motor_speed_pi_controller_tb.sv]
// ----------------------------------------------------------------------------
// motor_speed_pi_controller_tb
// Self-checking testbench for the event driven PI speed regulator. Event
// words go in through a valid/ready channel. A scoreboard class keeps its own
// copy of the controller state and settings and predicts one result word per
// accepted event. It compares each returned word field by field, in order.
// The run covers directed corner cases and then random phases under several
// gain, limit and divider settings, with idle and stall patterns on both sides.
// ----------------------------------------------------------------------------
module motor_speed_pi_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mspi_pkg::*;

  localparam int ClkPeriod    = 10;
  localparam int ResetCycles  = 9;
  localparam int QuietLimit   = 2000;
  localparam int LongHold     = 200;
  localparam int SettleCycles = 4;
  localparam int PhaseWords   = 270;
  localparam int MaxGap       = 40;
  localparam longint DriveMax = (longint'(1) << (DriveW - 1)) - 1;
  localparam longint DriveMin = -(longint'(1) << (DriveW - 1));

  // One event word and one result word, as seen on the ports.
  typedef struct {
    opcode_e            op;
    logic [SpeedW-1:0]  speed;
    logic [DreqW-1:0]   dreq;
    logic [DeltaW-1:0]  delta;
    logic               level;
  } pi_event_t;

  typedef struct {
    logic signed [DriveW-1:0] drive;
    logic                     updated;
    logic                     dir_pin;
    logic signed [PosW-1:0]   position;
    logic                     edge_err;
  } pi_result_t;

  // Tracks the controller state, predicts result words and checks them.
  class pi_loop_scoreboard;
    logic [GainW-1:0]         prop_gain;
    logic [GainW-1:0]         integ_gain;
    logic [LimitW-1:0]        integ_limit;
    logic [DivW-1:0]          tick_div;
    logic [SpeedW-1:0]        target;
    logic signed [DriveW-1:0] integral;
    logic [DivW-1:0]          tick_count;
    logic [PosW-1:0]          position;
    logic                     sensed_dir;
    logic signed [DriveW-1:0] drive;
    logic                     dir_pin;
    pi_result_t               pending[$];
    int                       errors;

    function new();
      prop_gain   = PropGainRst;
      integ_gain  = IntegGainRst;
      integ_limit = IntegLimRst;
      tick_div    = TickDivRst;
      target      = '0;
      integral    = '0;
      tick_count  = '0;
      position    = '0;
      sensed_dir  = DirForward;
      drive       = '0;
      dir_pin     = DirForward;
      errors      = 0;
    endfunction

    function void load_register(cfg_idx_e idx, logic [CfgDatW-1:0] data);
      case (idx)
        CfgPropGain:  prop_gain = data;
        CfgIntegGain: integ_gain = data;
        CfgIntegLim:  integ_limit = data[LimitW-1:0];
        CfgTickDiv:   tick_div = data[DivW-1:0];
        default: ;
      endcase
    endfunction

    // Encoder counts move the total in the currently sensed direction.
    function void move_position(logic [DeltaW-1:0] delta);
      if (sensed_dir == DirForward) begin
        position = position + PosW'(delta);
      end else begin
        position = position - PosW'(delta);
      end
    endfunction

    // Applies one accepted event and queues the result word it must produce.
    function void note_event(pi_event_t ev);
      pi_result_t res;
      int         err;
      int         acc;
      int         lim;
      longint     sum;
      longint     quot;
      res.updated  = 1'b0;
      res.edge_err = 1'b0;
      case (ev.op)
        OpCommand: begin
          target   = ev.speed;
          dir_pin  = (ev.dreq == DreqReverse) ? ~DirForward : DirForward;
          drive    = DriveW'(ev.speed);
          position = '0;
          integral = '0;
          res.updated = 1'b1;
        end
        OpTick: begin
          if (tick_count == tick_div) begin
            // Regulation step: clamp the integral, then scale and saturate.
            tick_count = '0;
            move_position(ev.delta);
            err = int'(target) - int'(ev.delta);
            lim = int'(integ_limit);
            acc = int'(integral) + err;
            if (acc > lim) begin
              acc = lim;
            end else if (acc < -lim) begin
              acc = -lim;
            end
            integral = acc[DriveW-1:0];
            sum = longint'(err) * longint'(prop_gain)
                + longint'(acc) * longint'(integ_gain);
            if (err != 0) begin
              quot = sum / (longint'(1) << FracBits);
              if (quot > DriveMax) begin
                quot = DriveMax;
              end else if (quot < DriveMin) begin
                quot = DriveMin;
              end
              drive = quot[DriveW-1:0];
              res.updated = 1'b1;
            end
          end else begin
            tick_count = tick_count + 1'b1;
          end
        end
        OpDirEdge: begin
          if (ev.level != sensed_dir) begin
            move_position(ev.delta);
            sensed_dir = ev.level;
          end else begin
            res.edge_err = 1'b1;
          end
        end
        default: begin
          position = position + OvfStep;
        end
      endcase
      res.drive    = drive;
      res.dir_pin  = dir_pin;
      res.position = position;
      pending.push_back(res);
    endfunction

    function void compare_field(string name, logic signed [63:0] want,
                                logic signed [63:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(pi_result_t got);
      pi_result_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result word with no event pending, drive %0d position %0d",
                 $time, got.drive, got.position);
        return;
      end
      want = pending.pop_front();
      compare_field("drive_value", want.drive, got.drive);
      compare_field("drive_updated", want.updated, got.updated);
      compare_field("direction_pin", want.dir_pin, got.dir_pin);
      compare_field("position_total", want.position, got.position);
      compare_field("edge_error", want.edge_err, got.edge_err);
    endfunction
  endclass

  logic                     clk_i               = 1'b0;
  logic                     rst_ni              = 1'b0;
  logic                     cfg_valid_i         = 1'b0;
  logic                     cfg_ready_o;
  logic [CfgIdxW-1:0]       cfg_index_i         = '0;
  logic [CfgDatW-1:0]       cfg_data_i          = '0;
  logic                     in_valid_i          = 1'b0;
  logic                     in_ready_o;
  logic [OpW-1:0]           opcode_i            = '0;
  logic [SpeedW-1:0]        target_speed_i      = '0;
  logic [DreqW-1:0]         direction_request_i = '0;
  logic [DeltaW-1:0]        encoder_delta_i     = '0;
  logic                     direction_level_i   = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i         = 1'b0;
  logic signed [DriveW-1:0] drive_value_o;
  logic                     drive_updated_o;
  logic                     direction_pin_o;
  logic signed [PosW-1:0]   position_total_o;
  logic                     edge_error_o;

  pi_loop_scoreboard sb = new();

  // Idle and stall rates in percent, and the request for one long stall.
  int                src_idle_pct  = 0;
  int                sink_stall_pct = 0;
  bit                long_hold_req = 1'b0;
  logic [SpeedW-1:0] cur_target    = '0;

  motor_speed_pi_controller dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .opcode_i           (opcode_i),
    .target_speed_i     (target_speed_i),
    .direction_request_i(direction_request_i),
    .encoder_delta_i    (encoder_delta_i),
    .direction_level_i  (direction_level_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .drive_value_o      (drive_value_o),
    .drive_updated_o    (drive_updated_o),
    .direction_pin_o    (direction_pin_o),
    .position_total_o   (position_total_o),
    .edge_error_o       (edge_error_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Every handshake is observed at the clock edge, before the design updates.
  always @(posedge clk_i) begin : channel_monitor
    pi_event_t  ev;
    pi_result_t res;
    if (in_valid_i && in_ready_o) begin
      ev.op    = opcode_e'(opcode_i);
      ev.speed = target_speed_i;
      ev.dreq  = direction_request_i;
      ev.delta = encoder_delta_i;
      ev.level = direction_level_i;
      sb.note_event(ev);
    end
    if (out_valid_o && out_ready_i) begin
      res.drive    = drive_value_o;
      res.updated  = drive_updated_o;
      res.dir_pin  = direction_pin_o;
      res.position = position_total_o;
      res.edge_err = edge_error_o;
      sb.check_result(res);
    end
    if (cfg_valid_i && cfg_ready_o) begin
      sb.load_register(cfg_idx_e'(cfg_index_i), cfg_data_i);
    end
  end

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // Ends the run when no channel moves a word for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("DONE: errors detected");
    $finish;
  end

  function automatic pi_event_t make_event(opcode_e op, logic [SpeedW-1:0] speed,
                                           logic [DreqW-1:0] dreq,
                                           logic [DeltaW-1:0] delta, logic level);
    pi_event_t ev;
    ev.op    = op;
    ev.speed = speed;
    ev.dreq  = dreq;
    ev.delta = delta;
    ev.level = level;
    return ev;
  endfunction

  // Mostly ticks with deltas close to the commanded speed, so the loop
  // settles and the integral moves; the rest is wide or noisy content.
  function automatic pi_event_t random_event(bit force_cmd);
    pi_event_t ev;
    int        pick;
    int        d;
    pick     = force_cmd ? 0 : $urandom_range(99);
    ev.speed = SpeedW'($urandom);
    ev.dreq  = $urandom_range(1) ? DreqReverse : DreqW'($urandom);
    ev.delta = DeltaW'($urandom);
    ev.level = 1'($urandom);
    if (pick < 6) begin
      ev.op = OpCommand;
    end else if (pick < 68) begin
      ev.op = OpTick;
    end else if (pick < 86) begin
      ev.op = OpDirEdge;
    end else begin
      ev.op = OpOverflow;
    end
    if (ev.op == OpCommand) begin
      cur_target = ev.speed;
    end else begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        d = int'(cur_target) + int'($urandom_range(6)) - 3;
        if (d < 0) begin
          d = 0;
        end
        ev.delta = DeltaW'(d);
      end else if (pick < 85) begin
        ev.delta = DeltaW'($urandom_range(511));
      end
    end
    return ev;
  endfunction

  // Offers one event word after a random gap. Valid stays high after the
  // word is taken; the next call or settle() replaces or drops it at once.
  task automatic send_event(pi_event_t ev);
    int gap;
    gap = 0;
    while (gap < MaxGap && $urandom_range(99) < src_idle_pct) begin
      gap++;
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i          <= 1'b1;
    opcode_i            <= ev.op;
    target_speed_i      <= ev.speed;
    direction_request_i <= ev.dreq;
    encoder_delta_i     <= ev.delta;
    direction_level_i   <= ev.level;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering words and waits until every result word is back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_register(cfg_idx_e idx, logic [CfgDatW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic apply_settings(logic [GainW-1:0] pg, logic [GainW-1:0] ig,
                                logic [LimitW-1:0] lim, logic [DivW-1:0] div);
    write_register(CfgPropGain, pg);
    write_register(CfgIntegGain, ig);
    write_register(CfgIntegLim, CfgDatW'(lim));
    write_register(CfgTickDiv, CfgDatW'(div));
    cfg_valid_i <= 1'b0;
  endtask

  // One random phase, opened by a speed command; pauses now and then.
  task automatic run_phase(bit with_hold);
    int n;
    send_event(random_event(1'b1));
    if (with_hold) begin
      long_hold_req = 1'b1;
    end
    for (n = 1; n < PhaseWords; n++) begin
      if ($urandom_range(199) == 0) begin
        settle();
      end
      send_event(random_event(1'b0));
    end
    settle();
  endtask

  initial begin : stimulus
    pi_event_t directed[$];
    int        p;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: commands both ways, skipped and regulating ticks,
    // zero error, negative saturation, edges and overflows.
    apply_settings(PropGainRst, IntegGainRst, IntegLimRst, 8'd2);
    directed.push_back(make_event(OpCommand, 8'd100, DreqReverse, 16'h1234, 1'b0));
    directed.push_back(make_event(OpCommand, 8'hFF, 8'hFE, 16'h0000, 1'b1));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'hFFFF, 1'b1));
    directed.push_back(make_event(OpTick, 8'hFF, 8'hFF, 16'h0007, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'd255, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'h0000, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'h0000, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'hFFFF, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'h0000, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'h0000, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'h0000, 1'b0));
    directed.push_back(make_event(OpDirEdge, 8'h00, 8'h00, 16'h0055, 1'b1));
    directed.push_back(make_event(OpDirEdge, 8'h00, 8'h00, 16'hFFFF, 1'b0));
    directed.push_back(make_event(OpOverflow, 8'hFF, 8'hFF, 16'hFFFF, 1'b1));
    directed.push_back(make_event(OpDirEdge, 8'h00, 8'h00, 16'h0100, 1'b0));
    directed.push_back(make_event(OpDirEdge, 8'h00, 8'h00, 16'd1234, 1'b1));
    directed.push_back(make_event(OpOverflow, 8'h00, 8'h00, 16'h0000, 1'b0));
    directed.push_back(make_event(OpCommand, 8'h00, 8'h00, 16'h0000, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'd300, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'd300, 1'b0));
    directed.push_back(make_event(OpTick, 8'h00, 8'h00, 16'd300, 1'b0));
    directed.push_back(make_event(OpCommand, 8'hAA, 8'h55, 16'h5555, 1'b1));
    foreach (directed[i]) begin
      send_event(directed[i]);
    end
    settle();

    // Random phases: settings move between the extremes and the divider
    // drops below a high tick count so the count has to wrap around.
    for (p = 0; p < 6; p++) begin
      case (p)
        0: begin
          apply_settings(PropGainRst, IntegGainRst, IntegLimRst, TickDivRst);
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          apply_settings(16'hFFFF, 16'hFFFF, 15'h7FFF, 8'd0);
          src_idle_pct = 62;
          sink_stall_pct = 0;
        end
        2: begin
          apply_settings(16'h0000, 16'hFFFF, 15'h0000, 8'd1);
          src_idle_pct = 0;
          sink_stall_pct = 62;
        end
        3: begin
          apply_settings(16'hFFFF, 16'h0000, 15'h7FFF, 8'hFF);
          src_idle_pct = 9;
          sink_stall_pct = 9;
        end
        4: begin
          apply_settings(GainW'($urandom), GainW'($urandom), LimitW'($urandom),
                         DivW'($urandom_range(2, 6)));
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        default: begin
          apply_settings(GainW'($urandom), GainW'($urandom),
                         LimitW'($urandom_range(1000)), DivW'($urandom_range(15)));
          src_idle_pct = 9;
          sink_stall_pct = 9;
        end
      endcase
      run_phase(p == 4);
    end

    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[motor_speed_pi_controller.f]
rtl/core/mspi_pkg.sv
rtl/core/motor_speed_pi_controller.sv
verif/motor_speed_pi_controller_tb.sv
